@@ hdl/jsu_pkg.sv @@
// Shared types, character codes and helpers for the JSON string escape unit.
// Used by jsu_front, jsu_queue, jsu_back and the top level.
package jsu_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam logic [7:0] B_BS  = 8'h08;
  localparam logic [7:0] B_TAB = 8'h09;
  localparam logic [7:0] B_LF  = 8'h0a;
  localparam logic [7:0] B_FF  = 8'h0c;
  localparam logic [7:0] B_CR  = 8'h0d;
  localparam logic [7:0] B_SPACE = 8'h20;

  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hbf;
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD_E0 = 8'he0;
  localparam logic [7:0] LEAD_ED = 8'hed;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD_F0 = 8'hf0;
  localparam logic [7:0] LEAD_F4 = 8'hf4;
  localparam logic [7:0] E0_LO = 8'ha0;
  localparam logic [7:0] ED_HI = 8'h9f;
  localparam logic [7:0] F0_LO = 8'h90;
  localparam logic [7:0] F4_HI = 8'h8f;

  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_PLAIN,
    BODY_SHORT,
    BODY_UNICODE
  } body_kind_e;

  typedef struct packed {
    logic       open;
    body_kind_e kind;
    logic [7:0] data;
    logic       close;
    logic       err;
  } desc_t;

  function automatic logic [2:0] body_len(input body_kind_e kind);
    logic [2:0] len;
    unique case (kind)
      BODY_NONE:    len = 3'd0;
      BODY_PLAIN:   len = 3'd1;
      BODY_SHORT:   len = 3'd2;
      BODY_UNICODE: len = 3'd6;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'b0, d};
    else c = 8'h57 + {4'b0, d};
    return c;
  endfunction

endpackage

@@ hdl/json_string_escape_utf8_check_unit.sv @@
// JSON string literal writer with strict UTF-8 check: top level.
// Accepted items pass through the descriptor queue to the back end.
// Throughput: one result per cycle unless stalled; an item gives 1 to 8
// results, via the single registered output stage of the back end.
// Reset: asynchronous active low, clears checker, queue and output valid.
module json_string_escape_utf8_check_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_string_i,
  input  logic       end_of_string_i,
  input  logic       empty_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       string_done_o,
  output logic       utf8_error_o
);
  import jsu_pkg::*;

  logic  push, full, pop, head_valid;
  desc_t desc, head;

  jsu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .start_of_string_i (start_of_string_i),
    .end_of_string_i   (end_of_string_i),
    .empty_string_i    (empty_string_i),
    .q_full_i          (full),
    .push_o            (push),
    .desc_o            (desc)
  );

  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_done_o (string_done_o),
    .utf8_error_o  (utf8_error_o)
  );

endmodule

@@ hdl/jsu_front.sv @@
// Front end: accepts input items, runs the UTF-8 checker and classifies each
// byte into a descriptor for the queue. Depends on jsu_pkg.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          start_of_string_i,
  input  logic          end_of_string_i,
  input  logic          empty_string_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::desc_t desc_o
);
  import jsu_pkg::*;

  logic [1:0] pend_q, pend_d, pend_c, pend_n;
  logic [7:0] lo_q, lo_d, lo_c, lo_n;
  logic [7:0] hi_q, hi_d, hi_c, hi_n;
  logic       err_q, err_d, err_c, err_n;
  logic       inside_q, inside_d;
  logic       fresh;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  always_comb begin
    fresh = start_of_string_i || !inside_q;
    pend_c = fresh ? 2'd0 : pend_q;
    lo_c   = fresh ? CONT_LO : lo_q;
    hi_c   = fresh ? CONT_HI : hi_q;
    err_c  = fresh ? 1'b0 : err_q;

    pend_n = pend_c;
    lo_n   = lo_c;
    hi_n   = hi_c;
    err_n  = err_c;
    if (pend_c != 2'd0) begin
      lo_n = CONT_LO;
      hi_n = CONT_HI;
      if (data_byte_i >= lo_c && data_byte_i <= hi_c) begin
        pend_n = pend_c - 2'd1;
      end else begin
        pend_n = 2'd0;
        err_n  = 1'b1;
      end
    end else if (data_byte_i[7]) begin
      priority if (data_byte_i >= LEAD2_LO && data_byte_i <= LEAD2_HI) begin
        pend_n = 2'd1; lo_n = CONT_LO; hi_n = CONT_HI;
      end else if (data_byte_i == LEAD_E0) begin
        pend_n = 2'd2; lo_n = E0_LO; hi_n = CONT_HI;
      end else if (data_byte_i == LEAD_ED) begin
        pend_n = 2'd2; lo_n = CONT_LO; hi_n = ED_HI;
      end else if (data_byte_i > LEAD_E0 && data_byte_i <= LEAD3_HI) begin
        pend_n = 2'd2; lo_n = CONT_LO; hi_n = CONT_HI;
      end else if (data_byte_i == LEAD_F0) begin
        pend_n = 2'd3; lo_n = F0_LO; hi_n = CONT_HI;
      end else if (data_byte_i > LEAD_F0 && data_byte_i < LEAD_F4) begin
        pend_n = 2'd3; lo_n = CONT_LO; hi_n = CONT_HI;
      end else if (data_byte_i == LEAD_F4) begin
        pend_n = 2'd3; lo_n = CONT_LO; hi_n = F4_HI;
      end else begin
        err_n = 1'b1;
      end
    end

    pend_d   = pend_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    err_d    = err_q;
    inside_d = inside_q;
    if (accept) begin
      if (empty_string_i || end_of_string_i) begin
        pend_d   = 2'd0;
        lo_d     = CONT_LO;
        hi_d     = CONT_HI;
        err_d    = 1'b0;
        inside_d = 1'b0;
      end else begin
        pend_d   = pend_n;
        lo_d     = lo_n;
        hi_d     = hi_n;
        err_d    = err_n;
        inside_d = 1'b1;
      end
    end

    desc_o.open  = empty_string_i || fresh;
    desc_o.close = empty_string_i || end_of_string_i;
    desc_o.err   = !empty_string_i && end_of_string_i && (err_n || pend_n != 2'd0);
    desc_o.data  = data_byte_i;
    if (empty_string_i) begin
      desc_o.kind = BODY_NONE;
    end else begin
      desc_o.kind = BODY_SHORT;
      unique case (data_byte_i)
        CH_QUOTE:  desc_o.data = CH_QUOTE;
        CH_BSLASH: desc_o.data = CH_BSLASH;
        B_BS:      desc_o.data = CH_LOW_B;
        B_FF:      desc_o.data = CH_LOW_F;
        B_LF:      desc_o.data = CH_LOW_N;
        B_CR:      desc_o.data = CH_LOW_R;
        B_TAB:     desc_o.data = CH_LOW_T;
        default:   desc_o.kind = (data_byte_i < B_SPACE) ? BODY_UNICODE : BODY_PLAIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 2'd0;
      lo_q     <= CONT_LO;
      hi_q     <= CONT_HI;
      err_q    <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      err_q    <= err_d;
      inside_q <= inside_d;
    end
  end

endmodule

@@ hdl/jsu_queue.sv @@
// Short descriptor queue between front end and back end.
// Depends on jsu_pkg.
module jsu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsu_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output jsu_pkg::desc_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  desc_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue push while full");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count out of range");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");

endmodule

@@ hdl/jsu_back.sv @@
// Back end: expands one descriptor into its output characters via a
// registered output stage, one per cycle unless stalled. Uses jsu_pkg.
module jsu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  jsu_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output logic           string_done_o,
  output logic           utf8_error_o
);
  import jsu_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       last_q, done_q, err_q;
  logic [2:0] len;
  logic [3:0] total;
  logic [2:0] last_idx;
  logic [2:0] j;
  logic       is_last;
  logic       advance;
  logic [7:0] ch;

  always_comb begin
    len      = body_len(head_i.kind);
    total    = {3'b0, head_i.open} + {1'b0, len} + {3'b0, head_i.close};
    last_idx = 3'(total - 4'd1);
    j        = idx_q - {2'b0, head_i.open};
    is_last  = (idx_q == last_idx);
    advance  = head_valid_i && (!out_valid_q || out_ready_i);
    pop_o    = advance && is_last;

    ch = CH_QUOTE;
    if (!(head_i.open && idx_q == 3'd0) && j < len) begin
      unique case (head_i.kind)
        BODY_PLAIN: ch = head_i.data;
        BODY_SHORT: ch = (j == 3'd0) ? CH_BSLASH : head_i.data;
        BODY_UNICODE: begin
          case (j)
            3'd0:    ch = CH_BSLASH;
            3'd1:    ch = CH_LOW_U;
            3'd4:    ch = hex_digit(head_i.data[7:4]);
            3'd5:    ch = hex_digit(head_i.data[3:0]);
            default: ch = CH_ZERO;
          endcase
        end
        default: ch = CH_QUOTE;
      endcase
    end

    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      idx_d       = is_last ? 3'd0 : idx_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= ch;
      last_q     <= is_last;
      done_q     <= is_last && head_i.close;
      err_q      <= is_last && head_i.close && head_i.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign string_done_o = done_q;
  assign utf8_error_o  = err_q;

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= last_idx)
    else $error("character index past end of run");

  a_done_is_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> out_byte_o == CH_QUOTE && last_of_run_o)
    else $error("string_done on a non-closing character");

  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && utf8_error_o |-> string_done_o)
    else $error("utf8_error without string_done");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o && last_of_run_o)
    else $error("descriptor popped without last character");

endmodule
